FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is high.
`define TSA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked property, checked during reset as well.
`define TSA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/tsa_pkg.sv
// Shared constants, codes and control/status types of the slot allocator.
package tsa_pkg;

  localparam int MAX_SLOTS_DEF = 64;
  localparam int MAX_NODES_DEF = 64;
  localparam logic [6:0] SLOT_COUNT_RST = 7'd32;

  // Command codes of an input word
  localparam logic [1:0] CMD_JOIN = 2'd0;
  localparam logic [1:0] CMD_FREE = 2'd1;
  localparam logic [1:0] CMD_REQ  = 2'd2;

  // Register byte address
  localparam logic [1:0] ADDR_SLOT_COUNT = 2'd0;

  // Slot table write address select
  typedef enum logic [1:0] {
    WA_I    = 2'd0,
    WA_PREF = 2'd1,
    WA_USED = 2'd2
  } wa_sel_t;

  // Slot table write data select
  typedef enum logic [1:0] {
    WD_NODE  = 2'd0,
    WD_PRIOR = 2'd1,
    WD_ID    = 2'd2
  } wd_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    ready;
    logic    load_item;
    logic    i_clr;
    logic    i_inc;
    logic    rd_slot;
    logic    rd_at_pref;
    logic    wr_slot;
    wa_sel_t wa_sel;
    wd_sel_t wd_sel;
    logic    set_rel;
    logic    clr_rel;
    logic    clr_all;
    logic    set_prior;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    need_load;
    logic    need_dec;
    logic    rd_req;
    logic    req_at_node;
    logic    wr_req;
    logic    id_set1;
    logic    id_inc;
    logic    pass_clr;
    logic    pass_inc;
    logic    used_clr;
    logic    used_inc;
    logic    any_clr;
    logic    any_set;
    logic    out_load;
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic       node_bad;
    logic [1:0] cmd;
    logic       pref_zero;
    logic       pref_ok;
    logic       eol;
    logic       i_last;
    logic       own_empty;
    logic       own_is_node;
    logic       own_is_id;
    logic       cand;
    logic       prior_moves;
    logic       disp;
    logic       req_le_have;
    logic       need_le_avail;
    logic       short_of;
    logic       req_zero;
    logic       grant;
    logic       used_last;
    logic       id_last;
    logic       pass_last;
    logic       any;
    logic       need_last;
    logic       out_free;
  } sts_t;

endpackage

FILE: design/tsa_if.sv
// Valid/ready channel interfaces for command words and map words.
interface tsa_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [5:0] node_id;
  logic [6:0] preferred_slot;
  logic       end_of_list;
  logic [6:0] requested_slots;

  modport source (output valid, command, node_id, preferred_slot, end_of_list,
                  requested_slots, input ready);
  modport sink (input valid, command, node_id, preferred_slot, end_of_list,
                requested_slots, output ready);
endinterface

interface tsa_map_if;
  logic       valid;
  logic       ready;
  logic [5:0] slot_index;
  logic [5:0] owner;
  logic       last;

  modport source (output valid, slot_index, owner, last, input ready);
  modport sink (input valid, slot_index, owner, last, output ready);
endinterface

FILE: design/tsa_ctrl.sv
// Sequencer of the slot allocator: one state per step of each table scan.
module tsa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  tsa_pkg::sts_t sts,
  output tsa_pkg::ctl_t ctl
);

  typedef enum logic [27:0] {
    S_IDLE    = 28'h0000001,
    S_DEC     = 28'h0000002,
    S_FE_RD   = 28'h0000004,
    S_FE_CHK  = 28'h0000008,
    S_PR_RD   = 28'h0000010,
    S_PR_CHK  = 28'h0000020,
    S_PR_WR   = 28'h0000040,
    S_JN_END  = 28'h0000080,
    S_FR_RD   = 28'h0000100,
    S_FR_CHK  = 28'h0000200,
    S_SC_RQ   = 28'h0000400,
    S_SC_EVAL = 28'h0000800,
    S_SC_RD   = 28'h0001000,
    S_SC_CNT  = 28'h0002000,
    S_SC_CMP  = 28'h0004000,
    S_RA_CLR  = 28'h0008000,
    S_RA_RQ   = 28'h0010000,
    S_RA_EVAL = 28'h0020000,
    S_HV_RD   = 28'h0040000,
    S_HV_CNT  = 28'h0080000,
    S_RQ_WR   = 28'h0100000,
    S_AV_RD   = 28'h0200000,
    S_AV_CNT  = 28'h0400000,
    S_AV_CMP  = 28'h0800000,
    S_TK_RD   = 28'h1000000,
    S_TK_CHK  = 28'h2000000,
    S_EM_RD   = 28'h4000000,
    S_EM_LD   = 28'h8000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    ctl = '0;
    ctl.wa_sel = tsa_pkg::WA_I;
    ctl.wd_sel = tsa_pkg::WD_NODE;
    case (state)
      S_IDLE: begin
        ctl.ready = 1'b1;
        if (in_valid) begin
          ctl.load_item = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        ctl.i_clr = 1'b1;
        ctl.cnt_clr = 1'b1;
        if (sts.node_bad) begin
          state_next = S_IDLE;
        end else if (sts.cmd == tsa_pkg::CMD_JOIN) begin
          if (sts.pref_zero) state_next = S_FE_RD;
          else if (sts.pref_ok) state_next = S_PR_RD;
          else state_next = S_JN_END;
        end else if (sts.cmd == tsa_pkg::CMD_FREE) begin
          state_next = S_FR_RD;
        end else if (sts.cmd == tsa_pkg::CMD_REQ) begin
          state_next = S_HV_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      // first empty slot search for a joining or displaced node
      S_FE_RD: begin
        ctl.rd_slot = 1'b1;
        state_next = S_FE_CHK;
      end
      S_FE_CHK: begin
        if (sts.own_empty) begin
          ctl.wr_slot = 1'b1;
          ctl.wd_sel = sts.disp ? tsa_pkg::WD_PRIOR : tsa_pkg::WD_NODE;
          state_next = sts.disp ? S_PR_WR : S_JN_END;
        end else begin
          ctl.i_inc = 1'b1;
          if (sts.i_last) state_next = sts.disp ? S_PR_WR : S_JN_END;
          else state_next = S_FE_RD;
        end
      end
      S_PR_RD: begin
        ctl.rd_slot = 1'b1;
        ctl.rd_at_pref = 1'b1;
        state_next = S_PR_CHK;
      end
      S_PR_CHK: begin
        ctl.set_prior = 1'b1;
        ctl.i_clr = 1'b1;
        state_next = sts.prior_moves ? S_FE_RD : S_PR_WR;
      end
      S_PR_WR: begin
        ctl.wr_slot = 1'b1;
        ctl.wa_sel = tsa_pkg::WA_PREF;
        state_next = S_JN_END;
      end
      S_JN_END: begin
        ctl.i_clr = 1'b1;
        state_next = sts.eol ? S_EM_RD : S_IDLE;
      end
      // free: mark the node's slots released
      S_FR_RD: begin
        ctl.rd_slot = 1'b1;
        state_next = S_FR_CHK;
      end
      S_FR_CHK: begin
        ctl.set_rel = sts.own_is_node;
        ctl.i_inc = 1'b1;
        if (sts.i_last) begin
          ctl.id_set1 = 1'b1;
          state_next = S_SC_RQ;
        end else begin
          state_next = S_FR_RD;
        end
      end
      // shortage check, one node at a time
      S_SC_RQ: begin
        ctl.rd_req = 1'b1;
        state_next = S_SC_EVAL;
      end
      S_SC_EVAL: begin
        if (sts.req_zero) begin
          ctl.id_inc = 1'b1;
          state_next = sts.id_last ? S_IDLE : S_SC_RQ;
        end else begin
          ctl.cnt_clr = 1'b1;
          ctl.i_clr = 1'b1;
          state_next = S_SC_RD;
        end
      end
      S_SC_RD: begin
        ctl.rd_slot = 1'b1;
        state_next = S_SC_CNT;
      end
      S_SC_CNT: begin
        ctl.cnt_inc = sts.own_is_id;
        ctl.i_inc = 1'b1;
        state_next = sts.i_last ? S_SC_CMP : S_SC_RD;
      end
      S_SC_CMP: begin
        if (sts.short_of) begin
          state_next = S_RA_CLR;
        end else begin
          ctl.id_inc = 1'b1;
          state_next = sts.id_last ? S_IDLE : S_SC_RQ;
        end
      end
      // full round-robin reassign
      S_RA_CLR: begin
        ctl.clr_all = 1'b1;
        ctl.used_clr = 1'b1;
        ctl.pass_clr = 1'b1;
        ctl.id_set1 = 1'b1;
        ctl.any_clr = 1'b1;
        state_next = S_RA_RQ;
      end
      S_RA_RQ: begin
        ctl.rd_req = 1'b1;
        state_next = S_RA_EVAL;
      end
      S_RA_EVAL: begin
        if (sts.grant) begin
          ctl.wr_slot = 1'b1;
          ctl.wa_sel = tsa_pkg::WA_USED;
          ctl.wd_sel = tsa_pkg::WD_ID;
          ctl.used_inc = 1'b1;
          ctl.any_set = 1'b1;
        end
        if (sts.grant && sts.used_last) begin
          ctl.i_clr = 1'b1;
          state_next = S_EM_RD;
        end else if (sts.id_last) begin
          if (!(sts.any || sts.grant) || sts.pass_last) begin
            ctl.i_clr = 1'b1;
            state_next = S_EM_RD;
          end else begin
            ctl.pass_inc = 1'b1;
            ctl.id_set1 = 1'b1;
            ctl.any_clr = 1'b1;
            state_next = S_RA_RQ;
          end
        end else begin
          ctl.id_inc = 1'b1;
          state_next = S_RA_RQ;
        end
      end
      // request: count owned slots
      S_HV_RD: begin
        ctl.rd_slot = 1'b1;
        state_next = S_HV_CNT;
      end
      S_HV_CNT: begin
        ctl.cnt_inc = sts.own_is_node;
        ctl.i_inc = 1'b1;
        state_next = sts.i_last ? S_RQ_WR : S_HV_RD;
      end
      S_RQ_WR: begin
        ctl.wr_req = 1'b1;
        if (sts.req_le_have) begin
          state_next = S_IDLE;
        end else begin
          ctl.need_load = 1'b1;
          ctl.cnt_clr = 1'b1;
          ctl.i_clr = 1'b1;
          state_next = S_AV_RD;
        end
      end
      // count released or empty slots
      S_AV_RD: begin
        ctl.rd_slot = 1'b1;
        state_next = S_AV_CNT;
      end
      S_AV_CNT: begin
        ctl.cnt_inc = sts.cand;
        ctl.i_inc = 1'b1;
        state_next = sts.i_last ? S_AV_CMP : S_AV_RD;
      end
      S_AV_CMP: begin
        ctl.i_clr = 1'b1;
        state_next = sts.need_le_avail ? S_TK_RD : S_RA_CLR;
      end
      // take free slots, lowest first
      S_TK_RD: begin
        ctl.rd_slot = 1'b1;
        state_next = S_TK_CHK;
      end
      S_TK_CHK: begin
        if (sts.cand) begin
          ctl.wr_slot = 1'b1;
          ctl.clr_rel = 1'b1;
          ctl.need_dec = 1'b1;
        end
        if ((sts.cand && sts.need_last) || sts.i_last) begin
          ctl.i_clr = 1'b1;
          state_next = S_EM_RD;
        end else begin
          ctl.i_inc = 1'b1;
          state_next = S_TK_RD;
        end
      end
      // map emission, one word per slot
      S_EM_RD: begin
        ctl.rd_slot = 1'b1;
        state_next = S_EM_LD;
      end
      S_EM_LD: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          ctl.i_inc = 1'b1;
          state_next = sts.i_last ? S_IDLE : S_EM_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/tsa_dpath.sv
// Slot table, request table, scan counters and output register.
module tsa_dpath #(
  parameter int MAX_SLOTS = tsa_pkg::MAX_SLOTS_DEF,
  parameter int MAX_NODES = tsa_pkg::MAX_NODES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [6:0]    slot_count,
  input  logic [1:0]    command,
  input  logic [5:0]    node_id,
  input  logic [6:0]    preferred_slot,
  input  logic          end_of_list,
  input  logic [6:0]    requested_slots,
  input  tsa_pkg::ctl_t ctl,
  output tsa_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [5:0]    slot_index,
  output logic [5:0]    owner,
  output logic          last
);

  localparam int SW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int ND = (MAX_NODES < 64) ? MAX_NODES : 64;
  localparam int NW = $clog2(ND);

  // item registers
  logic [1:0] cmd_q;
  logic [5:0] node_q;
  logic [6:0] pref_q;
  logic       eol_q;
  logic [6:0] reqn_q;

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      cmd_q  <= command;
      node_q <= node_id;
      pref_q <= preferred_slot;
      eol_q  <= end_of_list;
      reqn_q <= requested_slots;
    end
  end

  // active slot count, clamped to 1..MAX_SLOTS
  logic [CW-1:0] n;
  always_comb begin
    if (slot_count == 7'd0) n = CW'(1);
    else if (slot_count > 7'(MAX_SLOTS)) n = CW'(MAX_SLOTS);
    else n = CW'(slot_count);
  end

  // counters
  logic [CW-1:0] i, used;
  logic [6:0]    cnt, need, pass;
  logic [NW-1:0] id;
  logic          any, disp;
  logic [5:0]    prior_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      i <= '0;
      used <= '0;
      cnt <= '0;
      need <= '0;
      pass <= '0;
      id <= '0;
      any <= 1'b0;
      disp <= 1'b0;
    end else begin
      if (ctl.i_clr) i <= '0;
      else if (ctl.i_inc) i <= i + CW'(1);
      if (ctl.used_clr) used <= '0;
      else if (ctl.used_inc) used <= used + CW'(1);
      if (ctl.cnt_clr) cnt <= '0;
      else if (ctl.cnt_inc) cnt <= cnt + 7'd1;
      if (ctl.need_load) need <= reqn_q - cnt;
      else if (ctl.need_dec) need <= need - 7'd1;
      if (ctl.pass_clr) pass <= '0;
      else if (ctl.pass_inc) pass <= pass + 7'd1;
      if (ctl.id_set1) id <= NW'(1);
      else if (ctl.id_inc) id <= id + NW'(1);
      if (ctl.any_clr) any <= 1'b0;
      else if (ctl.any_set) any <= 1'b1;
      if (ctl.load_item) disp <= 1'b0;
      else if (ctl.set_prior) disp <= sts.prior_moves;
    end
  end

  // slot owner memory with valid and released flags
  logic [5:0]           own_mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] own_vld, rel;
  logic [5:0]           own_q;
  logic                 ovld_q, rel_q;
  logic [5:0]           eff_own;
  logic [SW-1:0]        pref_idx, ra, wa;
  logic [5:0]           wd;

  assign pref_idx = SW'(pref_q - 7'd1);
  assign ra = ctl.rd_at_pref ? pref_idx : i[SW-1:0];

  always_comb begin
    case (ctl.wa_sel)
      tsa_pkg::WA_PREF: wa = pref_idx;
      tsa_pkg::WA_USED: wa = used[SW-1:0];
      default:          wa = i[SW-1:0];
    endcase
    case (ctl.wd_sel)
      tsa_pkg::WD_PRIOR: wd = prior_q;
      tsa_pkg::WD_ID:    wd = 6'(id);
      default:           wd = node_q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_slot) own_mem[wa] <= wd;
    if (ctl.rd_slot) begin
      own_q  <= own_mem[ra];
      ovld_q <= own_vld[ra];
      rel_q  <= rel[ra];
    end
    if (ctl.set_prior) prior_q <= eff_own;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_vld <= '0;
      rel <= '0;
    end else if (ctl.clr_all) begin
      own_vld <= '0;
      rel <= '0;
    end else begin
      if (ctl.wr_slot) own_vld[wa] <= 1'b1;
      if (ctl.set_rel) rel[i[SW-1:0]] <= 1'b1;
      else if (ctl.clr_rel) rel[i[SW-1:0]] <= 1'b0;
    end
  end

  assign eff_own = ovld_q ? own_q : 6'd0;

  // requested count memory with valid flags
  logic [6:0]    req_mem [ND];
  logic [ND-1:0] req_vld;
  logic [6:0]    req_raw;
  logic          req_v;
  logic [6:0]    req_q;
  logic [NW-1:0] qa, node_a;

  assign node_a = node_q[NW-1:0];
  assign qa = ctl.req_at_node ? node_a : id;

  always_ff @(posedge clk) begin
    if (ctl.wr_req) req_mem[node_a] <= reqn_q;
    if (ctl.rd_req) begin
      req_raw <= req_mem[qa];
      req_v   <= req_vld[qa];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld <= '0;
    end else if (ctl.wr_req) begin
      req_vld[node_a] <= 1'b1;
    end
  end

  assign req_q = req_v ? req_raw : 7'd0;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      slot_index <= 6'(i);
      owner      <= eff_own;
      last       <= sts.i_last;
    end
  end

  // status to the sequencer
  always_comb begin
    sts.node_bad      = (node_q == 6'd0) || (32'(node_q) >= 32'(MAX_NODES));
    sts.cmd           = cmd_q;
    sts.pref_zero     = (pref_q == 7'd0);
    sts.pref_ok       = (pref_q != 7'd0) && (pref_q <= 7'(n));
    sts.eol           = eol_q;
    sts.i_last        = (i == n - CW'(1));
    sts.own_empty     = (eff_own == 6'd0);
    sts.own_is_node   = (eff_own == node_q);
    sts.own_is_id     = (eff_own == 6'(id));
    sts.cand          = rel_q || (eff_own == 6'd0);
    sts.prior_moves   = (eff_own != 6'd0) && (eff_own != node_q);
    sts.disp          = disp;
    sts.req_le_have   = (reqn_q <= cnt);
    sts.need_le_avail = (need <= cnt);
    sts.short_of      = (req_q > cnt);
    sts.req_zero      = (req_q == 7'd0);
    sts.grant         = (req_q > pass);
    sts.used_last     = (used + CW'(1) == n);
    sts.id_last       = (id == NW'(ND - 1));
    sts.pass_last     = (pass + 7'd1 == 7'(n));
    sts.any           = any;
    sts.need_last     = (need == 7'd1);
    sts.out_free      = !out_valid || out_ready;
  end

endmodule

FILE: design/tdma_slot_allocator_core.sv
// Top level of the TDMA slot allocator: register port, sequencer and datapath.
//
// Command words arrive on cmd_in (join, free, request); map words leave on
// map_out, one per active slot, index 0 first, last set on the final slot.
// The slot count register is written over the APB port; the user must write it only
// while the block idles, as the block itself does not enforce it. One command word is
// processed at a time; cmd_in.ready is high only between words. Every slot scan
// reads each slot from the registered table, then evaluates it.
// A request that needs more slots takes released or empty slots, lowest first, or
// reassigns all slots round robin when too few are free. Free marks the node's
// slots released, then checks each node with a nonzero request for a shortage
// and reassigns all slots when one is short.
// A map sends one word per slot. If map_out stalls, the sequencer holds until the
// output register frees; the last map word may still wait while the next
// command word is taken.
// Reset empties the slot table, clears released marks and requested counts
// and sets the slot count to 32; the tables need no clearing pass.
module tdma_slot_allocator_core #(
  parameter int MAX_SLOTS = tsa_pkg::MAX_SLOTS_DEF,
  parameter int MAX_NODES = tsa_pkg::MAX_NODES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  tsa_cmd_if.sink     cmd_in,
  tsa_map_if.source   map_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tsa_pkg::ctl_t ctl;
  tsa_pkg::sts_t sts;
  logic [6:0]    slot_count;

  // configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= tsa_pkg::SLOT_COUNT_RST;
    end else if (psel && penable && pwrite) begin
      slot_count <= pwdata[6:0];
    end
  end

  assign prdata = (paddr == tsa_pkg::ADDR_SLOT_COUNT) ? {25'd0, slot_count} : 32'd0;

  assign cmd_in.ready = ctl.ready;

  tsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd_in.valid),
    .sts      (sts),
    .ctl      (ctl)
  );

  tsa_dpath #(
    .MAX_SLOTS (MAX_SLOTS),
    .MAX_NODES (MAX_NODES)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .slot_count      (slot_count),
    .command         (cmd_in.command),
    .node_id         (cmd_in.node_id),
    .preferred_slot  (cmd_in.preferred_slot),
    .end_of_list     (cmd_in.end_of_list),
    .requested_slots (cmd_in.requested_slots),
    .ctl             (ctl),
    .sts             (sts),
    .out_valid       (map_out.valid),
    .out_ready       (map_out.ready),
    .slot_index      (map_out.slot_index),
    .owner           (map_out.owner),
    .last            (map_out.last)
  );

endmodule

FILE: design/tsa_checker.sv
// Port-level checks of the slot allocator, bound to the top level.
`include "assert_macros.svh"

module tsa_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_index,
  input logic [5:0] out_owner,
  input logic       out_last
);

  // the block comes out of reset ready for a word
  `TSA_ASSERT_ALWAYS(a_ready_after_reset, $fell(rst) |-> in_ready, "not ready after reset")

  // one word at a time: ready drops after each accepted word
  `TSA_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "ready held after accept")

  // a word still waiting while idle can only be the final map word
  `TSA_ASSERT(a_idle_pending_last, in_ready && out_valid |-> out_last, "idle with map unfinished")

  // a stalled map word holds
  `TSA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(out_owner), "map word dropped")

endmodule

bind tdma_slot_allocator_core tsa_checker u_tsa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (cmd_in.valid),
  .in_ready  (cmd_in.ready),
  .out_valid (map_out.valid),
  .out_ready (map_out.ready),
  .out_index (map_out.slot_index),
  .out_owner (map_out.owner),
  .out_last  (map_out.last)
);

FILE: dv/tb.sv
// Testbench for the TDMA slot allocator: directed table, random words, map checker.
`timescale 1ns / 1ps

module tb;

  localparam int NSLOT      = 64;
  localparam int NNODE      = 64;
  localparam int STALL_MAX  = 10;
  localparam int SETTLE     = 20000;
  localparam int WDOG_LIMIT = 60000;
  localparam logic [1:0] CMD_BAD = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] node_id;
    logic [6:0] preferred_slot;
    logic       end_of_list;
    logic [6:0] requested_slots;
  } cmd_word_t;

  typedef struct packed {
    cmd_word_t  w;
    logic       typed;   // owner of slot 0 known by inspection
    logic [5:0] owner0;
  } plan_row_t;

  typedef struct packed {
    logic [5:0] slot_index;
    logic [5:0] owner;
    logic       last;
  } map_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = tsa_pkg::ADDR_SLOT_COUNT;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tsa_cmd_if cmd_bus ();
  tsa_map_if map_bus ();

  tdma_slot_allocator_core u_top (
    .clk     (clk),
    .rst     (rst),
    .cmd_in  (cmd_bus),
    .map_out (map_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Allocator state as the block should hold it
  logic [5:0] tbl_owner [NSLOT];
  logic       tbl_rel   [NSLOT];
  logic [6:0] tbl_want  [NNODE];
  logic [6:0] slot_cfg;

  map_word_t map_expect [$];
  int        errors = 0;
  bit        calm = 1'b0;   // no gaps or stalls while set

  function automatic int active_n();
    if (slot_cfg == 0) return 1;
    if (slot_cfg > NSLOT) return NSLOT;
    return slot_cfg;
  endfunction

  function automatic int slots_of(int node, int n);
    int c;
    c = 0;
    for (int i = 0; i < n; i++) if (tbl_owner[i] == node) c++;
    return c;
  endfunction

  function automatic int first_free(int n);
    for (int i = 0; i < n; i++) if (tbl_owner[i] == 0) return i;
    return -1;
  endfunction

  // Clear the table and deal slots round robin by ascending node id
  function automatic void round_robin(int n);
    int left [NNODE];
    int used;
    used = 0;
    for (int id = 0; id < NNODE; id++) left[id] = tbl_want[id];
    for (int i = 0; i < NSLOT; i++) begin
      tbl_owner[i] = '0;
      tbl_rel[i] = 1'b0;
    end
    for (int p = 0; p < n && used < n; p++)
      for (int id = 1; id < NNODE && used < n; id++)
        if (left[id] > 0) begin
          tbl_owner[used] = 6'(id);
          left[id]--;
          used++;
        end
  endfunction

  function automatic void queue_map(int n);
    map_word_t m;
    for (int i = 0; i < n; i++) begin
      m.slot_index = 6'(i);
      m.owner = tbl_owner[i];
      m.last = (i == n - 1);
      map_expect = {map_expect, m};
    end
  endfunction

  // Update allocator state for one accepted word and queue the map it causes
  function automatic void alloc_predict(cmd_word_t w);
    int n, e, idx, have, need, avail;
    logic [5:0] prior;
    bit short_of;
    n = active_n();
    if (w.node_id == 0 || w.node_id >= NNODE) return;
    case (w.command)
      tsa_pkg::CMD_JOIN: begin
        if (w.preferred_slot == 0) begin
          e = first_free(n);
          if (e >= 0) tbl_owner[e] = w.node_id;
        end else if (w.preferred_slot <= n) begin
          idx = w.preferred_slot - 1;
          prior = tbl_owner[idx];
          if (prior != 0 && prior != w.node_id) begin
            e = first_free(n);
            if (e >= 0) tbl_owner[e] = prior;
          end
          tbl_owner[idx] = w.node_id;
        end
        if (w.end_of_list) queue_map(n);
      end
      tsa_pkg::CMD_FREE: begin
        short_of = 1'b0;
        for (int i = 0; i < n; i++) if (tbl_owner[i] == w.node_id) tbl_rel[i] = 1'b1;
        for (int id = 1; id < NNODE; id++)
          if (tbl_want[id] > slots_of(id, n)) short_of = 1'b1;
        if (short_of) begin
          round_robin(n);
          queue_map(n);
        end
      end
      tsa_pkg::CMD_REQ: begin
        have = slots_of(w.node_id, n);
        tbl_want[w.node_id] = w.requested_slots;
        if (w.requested_slots > have) begin
          need = w.requested_slots - have;
          avail = 0;
          for (int i = 0; i < n; i++) if (tbl_rel[i] || tbl_owner[i] == 0) avail++;
          if (need <= avail) begin
            for (int i = 0; i < n && need > 0; i++)
              if (tbl_rel[i] || tbl_owner[i] == 0) begin
                tbl_rel[i] = 1'b0;
                tbl_owner[i] = w.node_id;
                need--;
              end
          end else begin
            round_robin(n);
          end
          queue_map(n);
        end
      end
      default: ;
    endcase
  endfunction

  // Send one command word after a random gap, predict on acceptance
  task automatic send_word(cmd_word_t w, bit typed, logic [5:0] owner0);
    int gap, base;
    gap = calm ? 0 : $urandom_range(STALL_MAX);
    repeat (gap) begin
      @(negedge clk);
      cmd_bus.valid = 1'b0;
    end
    @(negedge clk);
    cmd_bus.valid = 1'b1;
    cmd_bus.command = w.command;
    cmd_bus.node_id = w.node_id;
    cmd_bus.preferred_slot = w.preferred_slot;
    cmd_bus.end_of_list = w.end_of_list;
    cmd_bus.requested_slots = w.requested_slots;
    do @(posedge clk); while (!cmd_bus.ready);
    base = map_expect.size();
    alloc_predict(w);
    if (typed && map_expect.size() > base) map_expect[base].owner = owner0;
  endtask

  task automatic reg_write(logic [6:0] value);
    @(negedge clk);
    cmd_bus.valid = 1'b0;
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = tsa_pkg::ADDR_SLOT_COUNT;
    pwdata = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    slot_cfg = value;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Drain expected words, then let a silent command finish
  task automatic settle();
    @(negedge clk);
    cmd_bus.valid = 1'b0;
    while (map_expect.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Random word, mostly well formed over a small pool of nodes
  function automatic cmd_word_t rand_word();
    cmd_word_t w;
    int n, sel;
    n = active_n();
    w.command = 2'($urandom_range(2));
    w.node_id = ($urandom_range(3) == 0) ? 6'($urandom_range(1, 63))
                                        : 6'($urandom_range(1, 8));
    w.preferred_slot = 7'($urandom);
    w.end_of_list = 1'($urandom);
    w.requested_slots = 7'($urandom);
    sel = $urandom_range(99);
    if (w.command == tsa_pkg::CMD_JOIN) begin
      if (sel < 70) w.preferred_slot = 7'($urandom_range(1, n));
      else if (sel < 85) w.preferred_slot = '0;
      w.end_of_list = ($urandom_range(9) < 3);
    end else if (w.command == tsa_pkg::CMD_REQ && sel < 85) begin
      w.requested_slots = 7'($urandom_range(0, n / 2 + 1));
    end
    return w;
  endfunction

  // Ignored word: null node or unused command
  function automatic cmd_word_t noise_word();
    cmd_word_t w;
    w = cmd_word_t'(23'($urandom));
    if ($urandom_range(1)) w.node_id = '0;
    else w.command = CMD_BAD;
    return w;
  endfunction

  // Map receiver with random stalls, checks against the oldest expectation
  initial begin
    map_word_t exp_w;
    int stall;
    map_bus.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = calm ? 0 : $urandom_range(STALL_MAX);
      repeat (stall) begin
        @(negedge clk);
        map_bus.ready = 1'b0;
      end
      @(negedge clk);
      map_bus.ready = 1'b1;
      do @(posedge clk); while (!map_bus.valid);
      if (map_expect.size() == 0) begin
        $display("%0t: unexpected map word idx=%0d owner=%0d last=%0d", $time,
                 map_bus.slot_index, map_bus.owner, map_bus.last);
        errors++;
      end else begin
        exp_w = map_expect.pop_front();
        if (map_bus.slot_index !== exp_w.slot_index) begin
          $display("%0t: slot_index expected %0d got %0d", $time,
                   exp_w.slot_index, map_bus.slot_index);
          errors++;
        end
        if (map_bus.owner !== exp_w.owner) begin
          $display("%0t: owner of slot %0d expected %0d got %0d", $time,
                   exp_w.slot_index, exp_w.owner, map_bus.owner);
          errors++;
        end
        if (map_bus.last !== exp_w.last) begin
          $display("%0t: last of slot %0d expected %0d got %0d", $time,
                   exp_w.slot_index, exp_w.last, map_bus.last);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no word moving
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((cmd_bus.valid && cmd_bus.ready) || (map_bus.valid && map_bus.ready) ||
          (psel && penable) || rst)
        idle = 0;
      else
        idle++;
      if (idle >= WDOG_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // Directed table, reset setting of 32 slots
  plan_row_t plan [19] = '{
    '{'{tsa_pkg::CMD_JOIN, 6'd5,  7'd0,   1'b1, 7'd0},   1'b1, 6'd5},
    '{'{tsa_pkg::CMD_JOIN, 6'd63, 7'd32,  1'b0, 7'd127}, 1'b0, 6'd0},
    '{'{tsa_pkg::CMD_JOIN, 6'd7,  7'd1,   1'b1, 7'd0},   1'b1, 6'd7},
    '{'{tsa_pkg::CMD_JOIN, 6'd9,  7'd33,  1'b1, 7'd0},   1'b1, 6'd7},
    '{'{tsa_pkg::CMD_JOIN, 6'd9,  7'd127, 1'b1, 7'd0},   1'b1, 6'd7},
    '{'{tsa_pkg::CMD_JOIN, 6'd21, 7'd64,  1'b0, 7'd0},   1'b0, 6'd0},
    '{'{tsa_pkg::CMD_JOIN, 6'd0,  7'd0,   1'b1, 7'd0},   1'b0, 6'd0},
    '{'{CMD_BAD,           6'd4,  7'd1,   1'b1, 7'd5},   1'b0, 6'd0},
    '{'{tsa_pkg::CMD_REQ,  6'd7,  7'd0,   1'b0, 7'd3},   1'b1, 6'd7},
    '{'{tsa_pkg::CMD_REQ,  6'd7,  7'd0,   1'b0, 7'd1},   1'b0, 6'd0},
    '{'{tsa_pkg::CMD_FREE, 6'd7,  7'd0,   1'b0, 7'd0},   1'b0, 6'd0},
    '{'{tsa_pkg::CMD_REQ,  6'd5,  7'd0,   1'b0, 7'd64},  1'b1, 6'd5},
    '{'{tsa_pkg::CMD_FREE, 6'd63, 7'd0,   1'b0, 7'd0},   1'b1, 6'd5},
    '{'{tsa_pkg::CMD_REQ,  6'd5,  7'd0,   1'b0, 7'd0},   1'b0, 6'd0},
    '{'{tsa_pkg::CMD_REQ,  6'd7,  7'd0,   1'b0, 7'd0},   1'b0, 6'd0},
    '{'{tsa_pkg::CMD_FREE, 6'd7,  7'd0,   1'b0, 7'd0},   1'b0, 6'd0},
    '{'{tsa_pkg::CMD_REQ,  6'd42, 7'd0,   1'b0, 7'd127}, 1'b1, 6'd42},
    '{'{tsa_pkg::CMD_JOIN, 6'd1,  7'd0,   1'b1, 7'd0},   1'b1, 6'd42},
    '{'{tsa_pkg::CMD_FREE, 6'd42, 7'd0,   1'b0, 7'd0},   1'b0, 6'd0}
  };

  // Slot count settings and random word budget per phase
  logic [6:0] phase_cfg   [6] = '{7'd8, 7'd1, 7'd64, 7'd0, 7'd127, 7'd5};
  int         phase_words [6] = '{50, 20, 18, 12, 8, 40};

  initial begin
    cmd_bus.valid = 1'b0;
    cmd_bus.command = tsa_pkg::CMD_JOIN;
    cmd_bus.node_id = '0;
    cmd_bus.preferred_slot = '0;
    cmd_bus.end_of_list = 1'b0;
    cmd_bus.requested_slots = '0;
    for (int i = 0; i < NSLOT; i++) begin
      tbl_owner[i] = '0;
      tbl_rel[i] = 1'b0;
    end
    for (int i = 0; i < NNODE; i++) tbl_want[i] = '0;
    slot_cfg = tsa_pkg::SLOT_COUNT_RST;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) send_word(plan[i].w, plan[i].typed, plan[i].owner0);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      reg_write(phase_cfg[ph]);
      calm = (ph == 2);
      for (int k = 0; k < phase_words[ph]; k++) begin
        if ($urandom_range(11) == 0) send_word(noise_word(), 1'b0, '0);
        send_word(rand_word(), 1'b0, '0);
      end
    end

    settle();
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
